>>> rtl/first_fit_segment_allocator_defines.svh
// Assertion macros shared by the allocator's checker.
// Depends on signals named clk and rst in the scope where a macro is used.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
// No dependencies.
package ffsa_pkg;

  localparam int NUM_SEG   = 32;
  localparam int IDX_W     = 5;
  localparam int LINK_W    = 6;
  localparam int ADDR_W    = 24;
  localparam int LEN_W     = 25;
  localparam int SIZE_W    = 26;
  localparam int ALIGN_DEF = 32;

  localparam logic [LEN_W-1:0]  POOL_RESET = 25'd1048576;
  localparam logic [LEN_W-1:0]  POOL_MAX   = LEN_W'(64'd1 << ADDR_W);
  localparam logic [LINK_W-1:0] NIL        = LINK_W'(NUM_SEG);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_NO_SPARE   = 3'd2,
    ST_ZERO       = 3'd3,
    ST_BAD_HANDLE = 3'd4
  } status_t;

  // One segment descriptor as held in the descriptor memory.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              is_free;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } desc_t;

endpackage

>>> rtl/ffsa_ifs.sv
// Request, response and configuration channels of the allocator.
// Depends on ffsa_pkg for field widths.
interface ffsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ffsa_pkg::LEN_W-1:0]  request_bytes;
  logic [ffsa_pkg::IDX_W-1:0]  handle_in;
  modport source (output valid, mode, request_bytes, handle_in, input ready);
  modport sink (input valid, mode, request_bytes, handle_in, output ready);
endinterface

interface ffsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [ffsa_pkg::IDX_W-1:0]  handle_out;
  logic [ffsa_pkg::ADDR_W-1:0] seg_address;
  logic [ffsa_pkg::LEN_W-1:0]  free_bytes;
  logic [ffsa_pkg::LEN_W-1:0]  min_free_bytes;
  modport source (output valid, status, handle_out, seg_address, free_bytes,
                  min_free_bytes, input ready);
  modport sink (input valid, status, handle_out, seg_address, free_bytes,
                min_free_bytes, output ready);
endinterface

interface ffsa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ffsa_pkg::LEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/first_fit_segment_allocator.sv
// First-fit segment allocator: sequencer over a 32-entry descriptor memory.
// Allocate: size rounding, a scan of the list entries (up to 32), then the
// descriptor updates and the response.
// Free: a bad handle goes straight to the response, a double free after the first read.
// Reset or a configuration write runs the init state S_INIT (request ready low).
// Depends on ffsa_pkg, ffsa_ifs, ffsa_ram and ffsa_align.
module first_fit_segment_allocator #(
  parameter int ALIGN_BYTES = ffsa_pkg::ALIGN_DEF
) (
  input logic        clk,
  input logic        rst,
  ffsa_req_if.sink   req,
  ffsa_rsp_if.source rsp,
  ffsa_cfg_if.sink   cfg
);
  import ffsa_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SIZE, S_SCAN, S_CARVE, S_PP, S_REST, S_PN, S_FIN,
    S_FHEAD, S_FPREV, S_FBEF, S_FNEXT, S_FNX, S_FAFT, S_FWB, S_RESP
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  pool;
  logic [IDX_W-1:0]  head;
  logic [NUM_SEG-1:0] in_list;
  logic [IDX_W-1:0]  stack [NUM_SEG];
  logic [LINK_W-1:0] count;
  logic [LEN_W-1:0]  bytes_free;
  logic [LEN_W-1:0]  bytes_low;
  logic [IDX_W-1:0]  p;
  logic [IDX_W-1:0]  steps;
  logic [SIZE_W-1:0] size;
  desc_t             dp;
  logic [IDX_W-1:0]  nidx;
  logic [LINK_W-1:0] lk;
  status_t           res_status;
  logic [IDX_W-1:0]  res_h;
  logic [ADDR_W-1:0] res_addr;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  desc_t             wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  desc_t             rdata;

  logic              al_start;
  logic              al_done;
  logic [SIZE_W-1:0] al_size;

  logic [LEN_W-1:0]  pool_sz;
  logic              fit;
  logic              exact;
  logic [LINK_W-1:0] cnt_m1;
  logic [IDX_W-1:0]  top_idx;
  logic [IDX_W-1:0]  new_idx;
  logic [LEN_W-1:0]  bf_sub;

  ffsa_ram #(.WIDTH($bits(desc_t)), .DEPTH(NUM_SEG)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  ffsa_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
    .clk(clk), .rst(rst), .start(al_start), .req_bytes(req.request_bytes),
    .done(al_done), .size(al_size)
  );

  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = 1'b1;

  // Helper values for the sequencer.
  always_comb begin
    pool_sz = (pool > POOL_MAX) ? POOL_MAX : pool;
    fit     = rdata.is_free && ({1'b0, rdata.length} >= size);
    exact   = ({1'b0, dp.length} == size);
    cnt_m1  = count - 1'b1;
    top_idx = cnt_m1[IDX_W-1:0];
    new_idx = stack[top_idx];
    bf_sub  = bytes_free - size[LEN_W-1:0];
  end

  // Memory port control: reads of the next entry and write-backs.
  always_comb begin
    we       = 1'b0;
    waddr    = p;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = p;
    al_start = 1'b0;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = IDX_W'(NUM_SEG - 1);
        wdata = '{start: '0, length: pool_sz, is_free: 1'b1, next: NIL, prev: NIL};
      end
      S_IDLE: begin
        if (req.valid && !cfg.valid) begin
          if (req.mode == MODE_ALLOC) begin
            al_start = (req.request_bytes != '0) && (count != '0);
          end else begin
            re    = in_list[req.handle_in];
            raddr = req.handle_in;
          end
        end
      end
      S_SIZE: begin
        re    = al_done;
        raddr = head;
      end
      S_SCAN: begin
        if (!fit && rdata.next != NIL && steps != IDX_W'(NUM_SEG - 1)) begin
          re    = 1'b1;
          raddr = rdata.next[IDX_W-1:0];
        end
      end
      S_CARVE: begin
        we    = 1'b1;
        waddr = new_idx;
        wdata = '{start: dp.start, length: size[LEN_W-1:0], is_free: 1'b0,
                  next: exact ? dp.next : {1'b0, p}, prev: dp.prev};
        re    = (dp.prev != NIL);
        raddr = dp.prev[IDX_W-1:0];
      end
      S_PP: begin
        we         = 1'b1;
        waddr      = dp.prev[IDX_W-1:0];
        wdata.next = {1'b0, nidx};
      end
      S_REST: begin
        if (exact) begin
          re    = (dp.next != NIL);
          raddr = dp.next[IDX_W-1:0];
        end else begin
          we    = 1'b1;
          waddr = p;
          wdata = '{start: dp.start + size[ADDR_W-1:0],
                    length: dp.length - size[LEN_W-1:0], is_free: 1'b1,
                    next: dp.next, prev: {1'b0, nidx}};
        end
      end
      S_PN: begin
        we         = 1'b1;
        waddr      = dp.next[IDX_W-1:0];
        wdata.prev = {1'b0, nidx};
      end
      S_FHEAD: begin
        re    = !rdata.is_free && (rdata.prev != NIL);
        raddr = rdata.prev[IDX_W-1:0];
      end
      S_FPREV: begin
        re    = rdata.is_free && (rdata.prev != NIL);
        raddr = rdata.prev[IDX_W-1:0];
      end
      S_FBEF: begin
        we         = 1'b1;
        waddr      = lk[IDX_W-1:0];
        wdata.next = {1'b0, p};
      end
      S_FNEXT: begin
        re    = (dp.next != NIL);
        raddr = dp.next[IDX_W-1:0];
      end
      S_FNX: begin
        re    = rdata.is_free && (rdata.next != NIL);
        raddr = rdata.next[IDX_W-1:0];
      end
      S_FAFT: begin
        we         = 1'b1;
        waddr      = lk[IDX_W-1:0];
        wdata.prev = {1'b0, p};
      end
      S_FWB: begin
        we    = 1'b1;
        waddr = p;
        wdata = dp;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, list bookkeeping and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      pool      <= POOL_RESET;
      rsp.valid <= 1'b0;
    end else begin
      // A taken response is cleared unless a new one replaces it this cycle.
      if (rsp.valid && rsp.ready && (cfg.valid || state != S_RESP)) begin
        rsp.valid <= 1'b0;
      end
      if (cfg.valid) begin
        pool  <= cfg.data;
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            head    <= IDX_W'(NUM_SEG - 1);
            in_list <= {1'b1, {(NUM_SEG - 1){1'b0}}};
            for (int i = 0; i < NUM_SEG; i++) begin
              stack[i] <= IDX_W'(i);
            end
            count      <= LINK_W'(NUM_SEG - 1);
            bytes_free <= pool_sz;
            bytes_low  <= pool_sz;
            state      <= S_IDLE;
          end
          S_IDLE: begin
            if (req.valid) begin
              res_h    <= '0;
              res_addr <= '0;
              if (req.mode == MODE_ALLOC) begin
                if (req.request_bytes == '0) begin
                  res_status <= ST_ZERO;
                  state      <= S_RESP;
                end else if (count == '0) begin
                  res_status <= ST_NO_SPARE;
                  state      <= S_RESP;
                end else begin
                  state <= S_SIZE;
                end
              end else begin
                p <= req.handle_in;
                if (!in_list[req.handle_in]) begin
                  res_status <= ST_BAD_HANDLE;
                  state      <= S_RESP;
                end else begin
                  state <= S_FHEAD;
                end
              end
            end
          end
          S_SIZE: begin
            if (al_done) begin
              size  <= al_size;
              p     <= head;
              steps <= '0;
              state <= S_SCAN;
            end
          end
          // One list entry per cycle until a free segment fits or the scan runs out.
          S_SCAN: begin
            if (fit) begin
              dp    <= rdata;
              state <= S_CARVE;
            end else if (rdata.next == NIL || steps == IDX_W'(NUM_SEG - 1)) begin
              res_status <= ST_NO_FIT;
              state      <= S_RESP;
            end else begin
              p     <= rdata.next[IDX_W-1:0];
              steps <= steps + 1'b1;
            end
          end
          // Pop a spare descriptor for the new segment.
          S_CARVE: begin
            nidx             <= new_idx;
            in_list[new_idx] <= 1'b1;
            count            <= cnt_m1;
            if (dp.prev == NIL) begin
              head  <= new_idx;
              state <= S_REST;
            end else begin
              state <= S_PP;
            end
          end
          S_PP: begin
            state <= S_REST;
          end
          // An emptied remainder goes back on the spare stack; else the remainder is written back.
          S_REST: begin
            if (exact) begin
              stack[count[IDX_W-1:0]] <= p;
              count                   <= count + 1'b1;
              in_list[p]              <= 1'b0;
              state                   <= (dp.next != NIL) ? S_PN : S_FIN;
            end else begin
              state <= S_FIN;
            end
          end
          S_PN: begin
            state <= S_FIN;
          end
          S_FIN: begin
            bytes_free <= bf_sub;
            if (bf_sub < bytes_low) begin
              bytes_low <= bf_sub;
            end
            res_status <= ST_OK;
            res_h      <= nidx;
            res_addr   <= dp.start;
            state      <= S_RESP;
          end
          S_FHEAD: begin
            if (rdata.is_free) begin
              res_status <= ST_BAD_HANDLE;
              state      <= S_RESP;
            end else begin
              dp         <= '{start: rdata.start, length: rdata.length, is_free: 1'b1,
                              next: rdata.next, prev: rdata.prev};
              bytes_free <= bytes_free + rdata.length;
              state      <= (rdata.prev != NIL) ? S_FPREV : S_FNEXT;
            end
          end
          // Merge with a free segment in front.
          S_FPREV: begin
            if (rdata.is_free) begin
              dp <= '{start: rdata.start, length: dp.length + rdata.length,
                      is_free: dp.is_free, next: dp.next, prev: rdata.prev};
              stack[count[IDX_W-1:0]]  <= dp.prev[IDX_W-1:0];
              count                    <= count + 1'b1;
              in_list[dp.prev[IDX_W-1:0]] <= 1'b0;
              if (rdata.prev != NIL) begin
                lk    <= rdata.prev;
                state <= S_FBEF;
              end else begin
                head  <= p;
                state <= S_FNEXT;
              end
            end else begin
              state <= S_FNEXT;
            end
          end
          S_FBEF: begin
            state <= S_FNEXT;
          end
          S_FNEXT: begin
            if (dp.next != NIL) begin
              lk    <= dp.next;
              state <= S_FNX;
            end else begin
              state <= S_FWB;
            end
          end
          // Merge with a free segment behind.
          S_FNX: begin
            if (rdata.is_free) begin
              dp <= '{start: dp.start, length: dp.length + rdata.length,
                      is_free: dp.is_free, next: rdata.next, prev: dp.prev};
              stack[count[IDX_W-1:0]] <= lk[IDX_W-1:0];
              count                   <= count + 1'b1;
              in_list[lk[IDX_W-1:0]]  <= 1'b0;
              if (rdata.next != NIL) begin
                lk    <= rdata.next;
                state <= S_FAFT;
              end else begin
                state <= S_FWB;
              end
            end else begin
              state <= S_FWB;
            end
          end
          S_FAFT: begin
            state <= S_FWB;
          end
          S_FWB: begin
            res_status <= ST_OK;
            state      <= S_RESP;
          end
          // Present the response once the output register is free.
          S_RESP: begin
            if (!rsp.valid || rsp.ready) begin
              rsp.valid          <= 1'b1;
              rsp.status         <= res_status;
              rsp.handle_out     <= res_h;
              rsp.seg_address    <= res_addr;
              rsp.free_bytes     <= bytes_free;
              rsp.min_free_bytes <= bytes_low;
              state              <= S_IDLE;
            end
          end
          default: begin
            state <= S_INIT;
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/ffsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ffsa_align.sv
// Round-up of a request size to a multiple of a power-of-two alignment.
// Depends on ffsa_pkg.
module ffsa_align #(
  parameter int ALIGN_BYTES = ffsa_pkg::ALIGN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ffsa_pkg::LEN_W-1:0]  req_bytes,
  output logic                        done,
  output logic [ffsa_pkg::SIZE_W-1:0] size
);
  import ffsa_pkg::*;

  // The alignment is a power of two, so rounding up is an add and a mask.
  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

  logic [SIZE_W-1:0] sum;

  // Add the alignment minus one; the extra top bit keeps the carry.
  always_comb begin
    sum = {1'b0, req_bytes} + ALIGN_MASK;
  end

  // The rounded size is registered, with done, in the cycle after start.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        size <= sum & ~ALIGN_MASK;
      end
    end
  end

endmodule

>>> rtl/ffsa_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on ffsa_pkg and first_fit_segment_allocator_defines.svh.
`include "first_fit_segment_allocator_defines.svh"

module ffsa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [2:0]                 status,
  input logic [ffsa_pkg::IDX_W-1:0]  handle_out,
  input logic [ffsa_pkg::ADDR_W-1:0] seg_address,
  input logic [ffsa_pkg::LEN_W-1:0]  free_bytes,
  input logic [ffsa_pkg::LEN_W-1:0]  min_free_bytes
);
  import ffsa_pkg::*;

  // A stalled response stays up.
  `FFSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
  // The low-water mark never exceeds the current free count.
  `FFSA_ASSERT_SAME(a_low_mark, rsp_valid, min_free_bytes <= free_bytes, "low mark above free")
  // Failed requests report no handle and no address.
  `FFSA_ASSERT_SAME(a_err_zero, rsp_valid && status != ST_OK,
                    handle_out == '0 && seg_address == '0, "error with payload")
  // The block works on one request at a time.
  `FFSA_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready, "second request taken")

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .handle_out(rsp.handle_out), .seg_address(rsp.seg_address),
  .free_bytes(rsp.free_bytes), .min_free_bytes(rsp.min_free_bytes)
);

>>> sim/first_fit_segment_allocator_tb.sv
// Self-checking testbench for the first-fit segment allocator.
// Depends on ffsa_pkg, the ffsa channel interfaces and first_fit_segment_allocator.
`timescale 1ns / 1ps

module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;

  localparam int N_RANDOM   = 2000;
  localparam int SETTLE     = 8;
  localparam int DRAIN      = 100;
  localparam int STALL_MAX  = 20000;

  typedef enum {K_CFG, K_REQ} item_kind_t;
  typedef enum {H_FIXED, H_LIVE, H_REFREE} handle_pick_t;

  typedef struct {
    item_kind_t        kind;
    logic [LEN_W-1:0]  pool;
    logic              mode;
    logic [LEN_W-1:0]  bytes;
    logic [IDX_W-1:0]  handle;
    handle_pick_t      pick;
  } pending_item_t;

  typedef struct {
    status_t           status;
    logic [IDX_W-1:0]  handle;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  free_b;
    logic [LEN_W-1:0]  low_b;
  } alloc_result_t;

  logic clk;
  logic rst;

  ffsa_req_if req_ch ();
  ffsa_rsp_if rsp_ch ();
  ffsa_cfg_if cfg_ch ();

  first_fit_segment_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  pending_item_t pend_q[$];
  alloc_result_t expected_q[$];
  int            errors;
  int            n_sent;
  int            quiet;
  int            stall_cnt;
  int            last_freed;

  // Shadow copy of the descriptor memory and the pool counters.
  logic [ADDR_W-1:0] sh_start [NUM_SEG];
  logic [LEN_W-1:0]  sh_len [NUM_SEG];
  bit                sh_free [NUM_SEG];
  bit                sh_inlist [NUM_SEG];
  int                sh_next [NUM_SEG];
  int                sh_prev [NUM_SEG];
  int                sh_spare [NUM_SEG];
  int                sh_head;
  int                sh_spare_n;
  logic [LEN_W-1:0]  sh_bytes_free;
  logic [LEN_W-1:0]  sh_bytes_low;

  function automatic void pool_reinit(logic [LEN_W-1:0] pb);
    logic [LEN_W-1:0] sz;
    sz = (pb > POOL_MAX) ? POOL_MAX : pb;
    for (int i = 0; i < NUM_SEG; i++) begin
      sh_start[i] = '0;
      sh_len[i] = '0;
      sh_free[i] = 0;
      sh_inlist[i] = 0;
      sh_next[i] = NUM_SEG;
      sh_prev[i] = NUM_SEG;
      sh_spare[i] = i;
    end
    sh_spare_n = NUM_SEG - 1;
    sh_head = NUM_SEG - 1;
    sh_free[sh_head] = 1;
    sh_inlist[sh_head] = 1;
    sh_len[sh_head] = sz;
    sh_bytes_free = sz;
    sh_bytes_low = sz;
  endfunction

  function automatic void release_desc(int d);
    sh_inlist[d] = 0;
    sh_free[d] = 0;
    sh_next[d] = NUM_SEG;
    sh_prev[d] = NUM_SEG;
    if (sh_spare_n < NUM_SEG) begin
      sh_spare[sh_spare_n] = d;
      sh_spare_n++;
    end
  endfunction

  // Carve a segment from the first free segment that fits.
  function automatic status_t carve(logic [LEN_W-1:0] req_b, output logic [IDX_W-1:0] h,
                                    output logic [ADDR_W-1:0] a);
    logic [SIZE_W-1:0] sz;
    int p, n, pp, pn, steps;
    h = '0;
    a = '0;
    if (req_b == 0) return ST_ZERO;
    if (sh_spare_n == 0) return ST_NO_SPARE;
    sz = ((SIZE_W'(req_b) + SIZE_W'(ALIGN_DEF - 1)) / ALIGN_DEF) * ALIGN_DEF;
    p = sh_head;
    for (steps = 0; steps < NUM_SEG && p < NUM_SEG; steps++) begin
      if (sh_free[p] && SIZE_W'(sh_len[p]) >= sz) break;
      p = sh_next[p];
    end
    if (steps >= NUM_SEG || p >= NUM_SEG) return ST_NO_FIT;
    sh_spare_n--;
    n = sh_spare[sh_spare_n] % NUM_SEG;
    sh_inlist[n] = 1;
    sh_free[n] = 0;
    sh_start[n] = sh_start[p];
    sh_len[n] = LEN_W'(sz);
    pp = sh_prev[p];
    sh_prev[n] = pp;
    if (pp < NUM_SEG) sh_next[pp] = n;
    else sh_head = n;
    sh_len[p] = sh_len[p] - LEN_W'(sz);
    if (sh_len[p] == 0) begin
      pn = sh_next[p];
      sh_next[n] = pn;
      if (pn < NUM_SEG) sh_prev[pn] = n;
      release_desc(p);
    end else begin
      sh_start[p] = sh_start[p] + ADDR_W'(sz);
      sh_prev[p] = n;
      sh_next[n] = p;
    end
    sh_bytes_free = sh_bytes_free - LEN_W'(sz);
    if (sh_bytes_free < sh_bytes_low) sh_bytes_low = sh_bytes_free;
    h = IDX_W'(n);
    a = sh_start[n];
    return ST_OK;
  endfunction

  // Mark a segment free and merge it with free neighbors.
  function automatic status_t release_seg(logic [IDX_W-1:0] hin);
    int h, pv, nx, bf, af;
    h = hin;
    if (!sh_inlist[h] || sh_free[h]) return ST_BAD_HANDLE;
    sh_free[h] = 1;
    sh_bytes_free = sh_bytes_free + sh_len[h];
    pv = sh_prev[h];
    if (pv < NUM_SEG && sh_free[pv]) begin
      bf = sh_prev[pv];
      sh_len[h] = sh_len[h] + sh_len[pv];
      sh_start[h] = sh_start[pv];
      release_desc(pv);
      sh_prev[h] = bf;
      if (bf < NUM_SEG) sh_next[bf] = h;
      else sh_head = h;
    end
    nx = sh_next[h];
    if (nx < NUM_SEG && sh_free[nx]) begin
      af = sh_next[nx];
      sh_len[h] = sh_len[h] + sh_len[nx];
      release_desc(nx);
      sh_next[h] = af;
      if (af < NUM_SEG) sh_prev[af] = h;
    end
    return ST_OK;
  endfunction

  // Pick a random allocated segment, or a random handle if none is allocated.
  function automatic logic [IDX_W-1:0] live_handle();
    int live[$];
    int p, steps;
    p = sh_head;
    for (steps = 0; steps < NUM_SEG && p < NUM_SEG; steps++) begin
      if (!sh_free[p]) live.push_back(p);
      p = sh_next[p];
    end
    if (live.size() == 0) return IDX_W'($urandom);
    return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic int phase_of(int n);
    if (n < N_RANDOM / 3) return 0;
    if (n < 2 * N_RANDOM / 3) return 1;
    return 2;
  endfunction

  // Clock and a single reset at the start.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    req_ch.valid = 0;
    req_ch.mode = MODE_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.handle_in = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    rsp_ch.ready = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
  end

  // Request driver: the shadow model is advanced at each accepted request.
  always @(posedge clk) begin
    alloc_result_t r;
    pending_item_t it;
    bit busy, idle;
    logic [IDX_W-1:0] h;
    int pct;
    if (rst) begin
      req_ch.valid <= 0;
      cfg_ch.valid <= 0;
      pool_reinit(POOL_RESET);
      last_freed = 0;
      n_sent = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        r.handle = '0;
        r.addr = '0;
        if (req_ch.mode == MODE_ALLOC) begin
          r.status = carve(req_ch.request_bytes, r.handle, r.addr);
        end else begin
          r.status = release_seg(req_ch.handle_in);
          if (r.status == ST_OK) last_freed = req_ch.handle_in;
        end
        r.free_b = sh_bytes_free;
        r.low_b = sh_bytes_low;
        expected_q.push_back(r);
        n_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) pool_reinit(cfg_ch.data);
      busy = (req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready);
      if (!busy) begin
        pct = (phase_of(n_sent) == 0) ? 34 : (phase_of(n_sent) == 1) ? 48 : 0;
        idle = ($urandom_range(0, 99) < pct);
        if (pend_q.size() > 0 && pend_q[0].kind == K_CFG) begin
          // Pool size changes only once the block has gone quiet.
          req_ch.valid <= 0;
          if (expected_q.size() == 0 && quiet >= SETTLE) begin
            it = pend_q.pop_front();
            cfg_ch.data <= it.pool;
            cfg_ch.valid <= 1;
          end else begin
            cfg_ch.valid <= 0;
          end
        end else if (pend_q.size() > 0 && !idle) begin
          it = pend_q.pop_front();
          case (it.pick)
            H_LIVE:   h = live_handle();
            H_REFREE: h = IDX_W'(last_freed);
            default:  h = it.handle;
          endcase
          req_ch.mode <= it.mode;
          req_ch.request_bytes <= it.bytes;
          req_ch.handle_in <= h;
          req_ch.valid <= 1;
          cfg_ch.valid <= 0;
        end else begin
          req_ch.valid <= 0;
          cfg_ch.valid <= 0;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  always @(posedge clk) begin
    alloc_result_t e;
    int pct;
    if (rst) begin
      rsp_ch.ready <= 0;
      quiet <= 0;
      errors = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response status=%0d", $time, rsp_ch.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (rsp_ch.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.handle_out !== e.handle) begin
            $display("%0t: handle_out expected %0d actual %0d", $time, e.handle,
                     rsp_ch.handle_out);
            errors++;
          end
          if (rsp_ch.seg_address !== e.addr) begin
            $display("%0t: seg_address expected %0h actual %0h", $time, e.addr,
                     rsp_ch.seg_address);
            errors++;
          end
          if (rsp_ch.free_bytes !== e.free_b) begin
            $display("%0t: free_bytes expected %0d actual %0d", $time, e.free_b,
                     rsp_ch.free_bytes);
            errors++;
          end
          if (rsp_ch.min_free_bytes !== e.low_b) begin
            $display("%0t: min_free_bytes expected %0d actual %0d", $time, e.low_b,
                     rsp_ch.min_free_bytes);
            errors++;
          end
        end
      end
      if (expected_q.size() != 0 || rsp_ch.valid) quiet <= 0;
      else quiet <= quiet + 1;
      pct = (phase_of(n_sent) == 0) ? 48 : (phase_of(n_sent) == 1) ? 34 : 0;
      rsp_ch.ready <= ($urandom_range(0, 99) >= pct);
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("first_fit_segment_allocator: mismatch");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic void add_cfg(logic [LEN_W-1:0] pb);
    pending_item_t it;
    it = '{kind: K_CFG, pool: pb, mode: MODE_ALLOC, bytes: '0, handle: '0, pick: H_FIXED};
    pend_q.push_back(it);
  endfunction

  function automatic void add_req(logic m, logic [LEN_W-1:0] b, logic [IDX_W-1:0] h,
                                  handle_pick_t pk);
    pending_item_t it;
    it = '{kind: K_REQ, pool: '0, mode: m, bytes: b, handle: h, pick: pk};
    pend_q.push_back(it);
  endfunction

  // Stimulus: directed corner cases, then random phases of pool sizes.
  initial begin
    int pool, lim, roll;
    logic [LEN_W-1:0] pools[5];
    // Reset pool: zero size, rounding, no fit, free and double free, bad handle.
    add_req(MODE_ALLOC, 25'd0, '0, H_FIXED);
    add_req(MODE_ALLOC, 25'd1, '0, H_FIXED);
    add_req(MODE_ALLOC, 25'd32, '0, H_FIXED);
    add_req(MODE_ALLOC, 25'd33, '0, H_FIXED);
    add_req(MODE_ALLOC, 25'h1FFFFFF, '0, H_FIXED);
    add_req(MODE_FREE, '0, '0, H_LIVE);
    add_req(MODE_FREE, '0, '0, H_REFREE);
    add_req(MODE_FREE, '0, 5'd0, H_FIXED);
    add_req(MODE_FREE, '0, 5'd31, H_FIXED);
    // Run out of spare descriptors.
    add_cfg(25'd1024);
    for (int i = 0; i < 32; i++) add_req(MODE_ALLOC, 25'd32, '0, H_FIXED);
    add_req(MODE_FREE, '0, '0, H_LIVE);
    // Smallest pool, then an oversized one that saturates.
    add_cfg(25'd32);
    add_req(MODE_ALLOC, 25'd32, '0, H_FIXED);
    add_req(MODE_ALLOC, 25'd1, '0, H_FIXED);
    add_cfg(25'h1FFFFFF);
    add_req(MODE_ALLOC, 25'd16777216, '0, H_FIXED);
    add_req(MODE_FREE, '0, '0, H_LIVE);

    pools = '{25'd4096, 25'd65536, 25'd16777216, 25'h1FFFFFF, 25'd1048576};
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        if ($urandom_range(0, 2) == 0) add_cfg(LEN_W'($urandom_range(32, 16777216)));
        else add_cfg(pools[$urandom_range(0, 4)]);
      end
      pool = (pend_q[$].kind == K_CFG) ? pend_q[$].pool : pool;
      lim = (pool > 16777216) ? 16777216 / 12 : pool / 12;
      if (lim < 1) lim = 1;
      roll = $urandom_range(0, 99);
      if (roll < 48) add_req(MODE_ALLOC, LEN_W'($urandom_range(1, lim)), '0, H_FIXED);
      else if (roll < 88) add_req(MODE_FREE, LEN_W'($urandom), '0, H_LIVE);
      else if (roll < 91) add_req(MODE_ALLOC, 25'd0, IDX_W'($urandom), H_FIXED);
      else if (roll < 95) add_req(MODE_FREE, LEN_W'($urandom), IDX_W'($urandom), H_FIXED);
      else if (roll < 97) add_req(MODE_FREE, '0, '0, H_REFREE);
      else add_req(MODE_ALLOC, LEN_W'($urandom), IDX_W'($urandom), H_FIXED);
    end

    @(negedge rst);
    while (pend_q.size() != 0 || req_ch.valid || cfg_ch.valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("first_fit_segment_allocator: match");
    end else begin
      $display("first_fit_segment_allocator: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_ifs.sv
rtl/ffsa_ram.sv
rtl/ffsa_align.sv
rtl/first_fit_segment_allocator.sv
rtl/ffsa_checker.sv
sim/first_fit_segment_allocator_tb.sv
